>>> sv/dpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended priority queue.
// Used by dpq_cell and double_ended_priority_queue.
package dpq_pkg;

  localparam int DATA_W        = 32;
  localparam int COUNT_FIELD_W = 7;
  localparam int CAPACITY_DEF  = 64;

  typedef enum logic [1:0] {
    OP_INSERT          = 2'd0,
    OP_REMOVE_LARGEST  = 2'd1,
    OP_REMOVE_SMALLEST = 2'd2,
    OP_CLEAR           = 2'd3
  } op_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] largest;
    logic signed [DATA_W-1:0] smallest;
    logic                     is_empty;
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic                     overflow;
  } rsp_t;

  // Broadcast to every cell in the chain for one update cycle.
  typedef struct packed {
    logic                     ins;      // insert ins_val into the sorted row
    logic                     shift;    // drop the smallest, shift all down by one
    logic signed [DATA_W-1:0] ins_val;
  } cell_ctrl_t;

  // Smallest power of two that is at least n.
  function automatic int pow2_ceil(input int n);
    int p;
    p = 1;
    while (p < n) p = p << 1;
    return p;
  endfunction

  // Register stages of a radix-2 OR tree over n leaves (n a power of two),
  // whose leaf nodes take up to four inputs.
  function automatic int tree_lat(input int n);
    int lat;
    int m;
    lat = 1;
    m   = n;
    while (m > 4) begin
      m   = m >> 1;
      lat = lat + 1;
    end
    return lat;
  endfunction

endpackage

>>> sv/dpq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted row: holds one entry, compares it with the insert
// value and trades entries with its neighbors. Depends on dpq_pkg.
module dpq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                             clk,
  input  dpq_pkg::cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                 count,
  input  logic signed [dpq_pkg::DATA_W-1:0] left_val,
  input  logic                             left_gt,
  input  logic signed [dpq_pkg::DATA_W-1:0] right_val,
  output logic signed [dpq_pkg::DATA_W-1:0] val,
  output logic                             gt,
  output logic [dpq_pkg::DATA_W-1:0]        top_val
);
  import dpq_pkg::*;

  logic occupied;
  logic at_end;
  logic is_top;

  assign occupied = CNT_W'(IDX) < count;
  assign at_end   = count == CNT_W'(IDX);
  assign is_top   = count == CNT_W'(IDX + 1);

  // Occupied and strictly above the new value: this entry moves up one slot.
  assign gt      = occupied && (val > ctrl.ins_val);
  assign top_val = is_top ? val : '0;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_gt) begin
        val <= left_val;
      end else if (gt || at_end) begin
        val <= ctrl.ins_val;
      end
    end else if (ctrl.shift) begin
      val <= right_val;
    end
  end

endmodule

>>> sv/dpq_or_tree.sv
`timescale 1ns / 1ps
// Registered OR reduction tree; one register level per node, leaves of up
// to four inputs. N must be a power of two. No package dependency.
module dpq_or_tree #(
  parameter int N = 4,
  parameter int W = 32
) (
  input  logic                clk,
  input  logic [N-1:0][W-1:0] leaves,
  output logic [W-1:0]        result
);

  if (N <= 4) begin : g_leaf
    logic [W-1:0] acc;

    always_comb begin
      acc = '0;
      for (int i = 0; i < N; i++) acc = acc | leaves[i];
    end

    always_ff @(posedge clk) begin
      result <= acc;
    end
  end else begin : g_node
    localparam int HALF = N / 2;
    logic [W-1:0] lo_res;
    logic [W-1:0] hi_res;

    dpq_or_tree #(.N(HALF), .W(W)) u_lo (
      .clk    (clk),
      .leaves (leaves[HALF-1:0]),
      .result (lo_res)
    );

    dpq_or_tree #(.N(N - HALF), .W(W)) u_hi (
      .clk    (clk),
      .leaves (leaves[N-1:HALF]),
      .result (hi_res)
    );

    always_ff @(posedge clk) begin
      result <= lo_res | hi_res;
    end
  end

endmodule

>>> sv/double_ended_priority_queue.sv
`timescale 1ns / 1ps
// Double-ended priority queue of signed 32-bit values (top level).
// Depends on dpq_pkg, dpq_cell and dpq_or_tree.
//
// Usage:
//   Requests arrive on req_valid/req_ready/req. Each request is one operation:
//   insert req.value, remove the largest, remove the smallest, or clear.
//   Every request yields exactly one response on rsp_valid/rsp_ready/rsp with
//   the largest and smallest entries after the operation (zero when empty),
//   the empty flag, the entry count and an overflow flag for an insert that
//   found the store full and was dropped.
//
// Structure and flow:
//   The entries sit in a row of CAPACITY cells kept in ascending order; an
//   insert or a remove-smallest updates the whole row in the accept cycle.
//   The largest entry is picked out by a registered OR tree over the cells,
//   TREE_LAT = 1 + log2(TREE_N / 4) stages (TREE_N = CAPACITY rounded up to
//   a power of two, at least one stage), so rsp_valid rises once the tree
//   has settled and the output register is free. One request is in flight
//   at a time and the input reopens as the response is loaded into the
//   output register.
//
// Reset clears the entry count and all handshake state; cell contents are
// left as they are. When the receiver stalls, the response is held in the
// output register and the next request is still taken; its response waits
// at the tree output until the output register frees up.
module double_ended_priority_queue #(
  parameter int CAPACITY = dpq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dpq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dpq_pkg::rsp_t rsp
);
  import dpq_pkg::*;

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TREE_N   = pow2_ceil(CAPACITY);
  localparam int TREE_LAT = tree_lat(TREE_N);
  localparam int SET_W    = $clog2(TREE_LAT + 1);
  localparam int EXT_W    = CNT_W + COUNT_FIELD_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [SET_W-1:0]   settle_cnt;
  logic               overflow;
  logic               req_fire;
  logic               full;
  logic               rsp_load;
  cell_ctrl_t         ctrl;
  logic [EXT_W-1:0]   count_ext;
  logic [DATA_W-1:0]  tree_max;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic                     cell_gt  [CAPACITY];
  logic [DATA_W-1:0]        cell_top [CAPACITY];
  logic [TREE_N-1:0][DATA_W-1:0] leaves;

  assign req_ready = state == ST_IDLE;
  assign req_fire  = req_valid && req_ready;
  assign full      = count == CNT_W'(CAPACITY);

  // Hand the result over once the tree has settled and the output
  // register is free or being emptied this cycle.
  assign rsp_load = (state == ST_BUSY) && (settle_cnt == '0) && (!rsp_valid || rsp_ready);

  // Row control: only insert and remove-smallest move entries.
  always_comb begin
    ctrl.ins     = req_fire && (req.operation == OP_INSERT) && !full;
    ctrl.shift   = req_fire && (req.operation == OP_REMOVE_SMALLEST) && (count != '0);
    ctrl.ins_val = req.value;
  end

  always_comb begin
    count_next = count;
    if (req_fire) begin
      case (req.operation)
        OP_INSERT: begin
          if (!full) count_next = count + CNT_W'(1);
        end
        OP_REMOVE_LARGEST, OP_REMOVE_SMALLEST: begin
          if (count != '0) count_next = count - CNT_W'(1);
        end
        OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) state_next = ST_BUSY;
      end
      ST_BUSY: begin
        if (rsp_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      settle_cnt <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      // Count down while the OR tree catches up with the new row.
      if (req_fire) begin
        settle_cnt <= SET_W'(TREE_LAT);
      end else if (settle_cnt != '0) begin
        settle_cnt <= settle_cnt - SET_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      overflow <= (req.operation == OP_INSERT) && full;
    end
  end

  // Sorted row of cells, smallest at index zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic                     left_gt;
    logic signed [DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_body
      assign right_val = cell_val[i+1];
    end

    dpq_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .val       (cell_val[i]),
      .gt        (cell_gt[i]),
      .top_val   (cell_top[i])
    );
  end

  // Only the topmost occupied cell drives a nonzero leaf.
  for (genvar j = 0; j < TREE_N; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_used
      assign leaves[j] = cell_top[j];
    end else begin : g_pad
      assign leaves[j] = '0;
    end
  end

  dpq_or_tree #(.N(TREE_N), .W(DATA_W)) u_tree (
    .clk    (clk),
    .leaves (leaves),
    .result (tree_max)
  );

  assign count_ext = EXT_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.largest     <= tree_max;
      rsp.smallest    <= (count == '0) ? '0 : cell_val[0];
      rsp.is_empty    <= count == '0;
      rsp.entry_count <= count_ext[COUNT_FIELD_W-1:0];
      rsp.overflow    <= overflow;
    end
  end

  // The entry count never runs past the row.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // A dropped insert leaves the count alone.
  a_full_drop : assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.operation == OP_INSERT) && full |=> count == $past(count))
    else $error("insert into full store changed the count");

  // An empty response carries zero extremes.
  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |-> (rsp.largest == '0) && (rsp.smallest == '0))
    else $error("empty response with nonzero extremes");

  // Accepting a request closes the input until its response is loaded.
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("second request taken while busy");

endmodule
